// ===== rtl/swst_pkg.sv =====
// Shared types and constants for the sliding window strider.
// Used by every module in rtl/ except swst_ram; depends on nothing.
package swst_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int MAX_CHANNELS = 4;
   localparam int WORD_W       = 32;
   localparam int SAMPLE_W     = WORD_W * MAX_CHANNELS;
   localparam int SLOT_W       = $clog2(MAX_WINDOW);
   localparam int PTR_W        = SLOT_W + 1;
   localparam int WIN_W        = 7;
   localparam int CHAN_W       = 3;
   localparam int STRIDE_W     = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int RSP_W        = 136;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE   = 2'd2;

   localparam logic [CHAN_W-1:0]   CHAN_RESET   = 3'd1;
   localparam logic [WIN_W-1:0]    WIN_RESET    = 7'd16;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd16;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   typedef struct packed {
      logic [PTR_W-1:0] start;
      logic [WIN_W-1:0] len;
   } win_cmd_type;

   typedef struct packed {
      logic             valid;
      logic [PTR_W-1:0] start;
   } guard_type;

   typedef struct packed {
      logic                last;
      logic [SLOT_W-1:0]   index;
      logic [SAMPLE_W-1:0] data;
   } row_type;

endpackage

// ===== rtl/swst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/swst_queue.sv =====
// Two-entry queue of window commands between front and back.
// Depends on swst_pkg.
module swst_queue
   import swst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  win_cmd_type push_cmd,
   input  logic        pop,
   output logic        head_valid,
   output win_cmd_type head,
   output logic        full
);

   win_cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

// ===== rtl/swst_front.sv =====
// Front end: configuration registers, sample intake, skip and fill tracking.
// Writes samples into the store and issues window commands. Depends on swst_pkg.
module swst_front
   import swst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STRIDE_W-1:0]  csr_data,
   input  logic                 queue_full,
   input  guard_type            guard,
   output logic                 push,
   output win_cmd_type          push_cmd,
   output logic                 wr_en,
   output logic [SLOT_W-1:0]    wr_addr,
   output logic [SAMPLE_W-1:0]  wr_data
);

   logic [CHAN_W-1:0]   chan_ff, chan_in;
   logic [WIN_W-1:0]    win_ff, win_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic [WIN_W-1:0]    fill_ff, fill_in;
   logic [STRIDE_W-1:0] skip_ff, skip_in;

   logic [CHAN_W-1:0]   chan_eff;
   logic [WIN_W-1:0]    win_eff;
   logic [STRIDE_W-1:0] stride_eff;
   logic [WIN_W-1:0]    fill_next;
   logic [PTR_W-1:0]    guard_dist;
   logic                write_ok;
   logic                req_acc;
   logic                csr_acc;
   logic                skipping;
   logic                stride_short;

   always_comb begin
      if (chan_ff == '0) begin
         chan_eff = CHAN_W'(1);
      end else if (chan_ff > CHAN_W'(MAX_CHANNELS)) begin
         chan_eff = CHAN_W'(MAX_CHANNELS);
      end else begin
         chan_eff = chan_ff;
      end
      if (win_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (win_ff > WIN_W'(MAX_WINDOW)) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = win_ff;
      end
      stride_eff = (stride_ff == '0) ? STRIDE_W'(1) : stride_ff;
   end

   assign guard_dist   = wp_ff - guard.start;
   assign write_ok     = !guard.valid || (guard_dist < PTR_W'(MAX_WINDOW));
   assign skipping     = (skip_ff != '0);
   assign req_tready   = !queue_full && (skipping || write_ok);
   assign req_acc      = req_tvalid && req_tready;
   assign csr_ready    = 1'b1;
   assign csr_acc      = csr_valid && csr_ready;
   assign fill_next    = fill_ff + 1'b1;
   assign stride_short = (stride_eff < STRIDE_W'(win_eff));

   always_comb begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (CHAN_W'(c) < chan_eff) begin
            wr_data[c*WORD_W +: WORD_W] = req_tdata[c*WORD_W +: WORD_W];
         end else begin
            wr_data[c*WORD_W +: WORD_W] = '0;
         end
      end
   end

   assign wr_en          = req_acc && !skipping;
   assign wr_addr        = wp_ff[SLOT_W-1:0];
   assign push           = wr_en && (fill_next == win_eff);
   assign push_cmd.start = wp_ff + 1'b1 - PTR_W'(win_eff);
   assign push_cmd.len   = win_eff;

   always_comb begin
      chan_in   = chan_ff;
      win_in    = win_ff;
      stride_in = stride_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      skip_in   = skip_ff;
      if (req_acc) begin
         if (skipping) begin
            skip_in = skip_ff - 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
            if (fill_next != win_eff) begin
               fill_in = fill_next;
            end else if (stride_short) begin
               fill_in = fill_next - stride_eff[WIN_W-1:0];
            end else begin
               fill_in = '0;
               skip_in = stride_eff - STRIDE_W'(win_eff);
            end
         end
      end
      if (csr_acc) begin
         priority if (csr_index == CSR_CHANNELS) begin
            chan_in = csr_data[CHAN_W-1:0];
            fill_in = '0;
            skip_in = '0;
         end else if (csr_index == CSR_WINDOW) begin
            win_in  = csr_data[WIN_W-1:0];
            fill_in = '0;
            skip_in = '0;
         end else if (csr_index == CSR_STRIDE) begin
            stride_in = csr_data;
            fill_in   = '0;
            skip_in   = '0;
         end else begin
            chan_in = chan_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff   <= CHAN_RESET;
         win_ff    <= WIN_RESET;
         stride_ff <= STRIDE_RESET;
         wp_ff     <= '0;
         fill_ff   <= '0;
         skip_ff   <= '0;
      end else begin
         chan_ff   <= chan_in;
         win_ff    <= win_in;
         stride_ff <= stride_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

// ===== rtl/swst_back.sv =====
// Back end: walks queued windows through the store and drives result rows.
// Output register plus skid stage cover the registered read. Depends on swst_pkg.
module swst_back
   import swst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  win_cmd_type         head,
   output logic                q_pop,
   output guard_type           guard,
   output logic                rd_en,
   output logic [SLOT_W-1:0]   rd_addr,
   input  logic [SAMPLE_W-1:0] rd_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,
   output logic                rsp_tlast
);

   back_state_type    state_ff, state_in;
   logic [PTR_W-1:0]  start_ff, start_in;
   logic [WIN_W-1:0]  len_ff, len_in;
   logic [SLOT_W-1:0] row_ff, row_in;
   logic              infl_ff, infl_in;
   logic [SLOT_W-1:0] infl_row_ff;
   logic              infl_last_ff;
   logic              out_v_ff, out_v_in;
   row_type           out_ff, out_in;
   logic              skid_v_ff, skid_v_in;
   row_type           skid_ff, skid_in;

   logic              pop;
   logic [1:0]        occ;
   logic [1:0]        occ_after;
   logic              issue;
   logic              is_last;
   logic              load;
   row_type           new_row;

   assign pop       = out_v_ff && rsp_tready;
   assign occ       = 2'(out_v_ff) + 2'(skid_v_ff) + 2'(infl_ff);
   assign occ_after = occ - 2'(pop);
   assign is_last   = (WIN_W'(row_ff) + 1'b1) == len_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (head_valid) begin
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (issue && is_last && !head_valid) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      issue = 1'b0;
      load  = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            load = 1'b1;
         end
         BACK_RUN: begin
            issue = (occ_after < 2'd2);
            load  = issue && is_last;
         end
         default: begin
            load = 1'b0;
         end
      endcase
      q_pop       = load && head_valid;
      guard.valid = (state_ff == BACK_RUN) || head_valid;
      guard.start = (state_ff == BACK_RUN) ? start_ff : head.start;
   end

   assign rd_en   = issue;
   assign rd_addr = start_ff[SLOT_W-1:0] + row_ff;

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      row_in   = row_ff;
      infl_in  = issue;
      if (q_pop) begin
         start_in = head.start;
         len_in   = head.len;
         row_in   = '0;
      end else if (issue) begin
         row_in = row_ff + 1'b1;
      end
   end

   assign new_row.last  = infl_last_ff;
   assign new_row.index = infl_row_ff;
   assign new_row.data  = rd_data;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (out_v_ff && !pop) begin
         if (infl_ff) begin
            skid_v_in = 1'b1;
            skid_in   = new_row;
         end
      end else if (skid_v_ff) begin
         out_v_in  = 1'b1;
         out_in    = skid_ff;
         skid_v_in = infl_ff;
         skid_in   = new_row;
      end else begin
         out_v_in = infl_ff;
         out_in   = new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BACK_IDLE;
         infl_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         infl_ff   <= infl_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      len_ff       <= len_in;
      row_ff       <= row_in;
      infl_row_ff  <= row_ff;
      infl_last_ff <= is_last;
      out_ff       <= out_in;
      skid_ff      <= skid_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{(RSP_W - SAMPLE_W - SLOT_W){1'b0}}, out_ff.index, out_ff.data};
   assign rsp_tlast  = out_ff.last;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid stage holds a row while the output register is empty");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      occ <= 2'd2)
      else $error("more rows in flight than the output buffers can hold");

   a_issue_in_run: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (state_ff == BACK_RUN))
      else $error("store read issued with no active window");

endmodule

// ===== rtl/sliding_window_strider.sv =====
// Top level of the sliding window strider: front, command queue, sample store, back.
// Depends on swst_pkg, swst_front, swst_queue, swst_ram, swst_back.
//
//   port group  dir  handshake              payload
//   req_*       in   req_tvalid/req_tready  req_tdata: 4 x 32-bit sample lanes
//   rsp_*       out  rsp_tvalid/rsp_tready  rsp_tdata: 4 lanes + row index; rsp_tlast
//   csr_*       in   csr_valid/csr_ready    csr_index, csr_data
//
// The front takes one sample per cycle while req_tready is high; the back walks a window
// of length W as W rows, one row per cycle from the registered store read while results
// are not stalled (W is 16 at reset values).
// Input stalls when two windows are queued, or when a write would overtake a window
// still being read. Reset is synchronous and clears control state only; the store
// has no clearing pass. Results stall freely behind the output register and skid stage.
module sliding_window_strider
   import swst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,   // sample_ch0, sample_ch1, sample_ch2, sample_ch3
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // row_ch0..row_ch3, row_index, zero fill
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STRIDE_W-1:0]  csr_data
);

   logic                queue_full;
   guard_type           guard;
   logic                push;
   win_cmd_type         push_cmd;
   logic                q_pop;
   logic                head_valid;
   win_cmd_type         head;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   logic [SAMPLE_W-1:0] wr_data;
   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   logic [SAMPLE_W-1:0] rd_data;

   swst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .guard      (guard),
      .push       (push),
      .push_cmd   (push_cmd),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   swst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head       (head),
      .full       (queue_full)
   );

   swst_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   swst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .q_pop      (q_pop),
      .guard      (guard),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== test/sliding_window_strider_tb.sv =====
// Self-checking testbench for sliding_window_strider: streams samples through the window framer
// and checks every emitted row against an in-bench framing predictor.
// Depends on swst_pkg and the sliding_window_strider RTL.
`timescale 1ns / 100ps

module sliding_window_strider_tb;
   import swst_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int ROW_INDEX_LSB = MAX_CHANNELS * WORD_W;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int TARGET_ITEMS  = 230;

   typedef enum {
      FLOW_STEADY,
      FLOW_SENDER_IDLE,
      FLOW_SINK_STALL,
      FLOW_BOTH_IDLE
   } flow_mode_type;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0][WORD_W-1:0] lane;
      logic [SLOT_W-1:0]                   index;
      logic                                last;
   } window_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CHANNELS;
   logic [STRIDE_W-1:0]  csr_data = '0;

   logic [SAMPLE_W-1:0] pending_samples[$];
   window_row_type      expected_rows[$];
   window_row_type      oldest_row;
   int                  samples_queued = 0;
   int                  samples_taken = 0;
   int                  fault_count = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct = 0;
   int                  sink_stall_pct = 0;
   bit                  sink_hold = 1'b0;

   // framing state mirrored from the block
   logic [CHAN_W-1:0]                   chan_setting = CHAN_RESET;
   logic [WIN_W-1:0]                    win_setting = WIN_RESET;
   logic [STRIDE_W-1:0]                 stride_setting = STRIDE_RESET;
   logic [MAX_CHANNELS-1:0][WORD_W-1:0] held_samples[MAX_WINDOW];
   int                                  head_slot = 0;
   int                                  held_count = 0;
   int                                  drop_count = 0;

   sliding_window_strider dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void apply_setting(logic [CSR_IDX_W-1:0] idx, logic [STRIDE_W-1:0] value);
      case (idx)
         CSR_CHANNELS: chan_setting = value[CHAN_W-1:0];
         CSR_WINDOW:   win_setting = value[WIN_W-1:0];
         CSR_STRIDE:   stride_setting = value;
         default:      return;
      endcase
      head_slot = 0;
      held_count = 0;
      drop_count = 0;
   endfunction

   function automatic void predict_window_rows(logic [SAMPLE_W-1:0] sample);
      int n_chan;
      int n_win;
      int n_stride;
      int slot;
      window_row_type row;
      n_chan = (chan_setting == 0) ? 1 : (chan_setting > MAX_CHANNELS) ? MAX_CHANNELS
             : int'(chan_setting);
      n_win = (win_setting == 0) ? 1 : (win_setting > MAX_WINDOW) ? MAX_WINDOW
            : int'(win_setting);
      n_stride = (stride_setting == 0) ? 1 : int'(stride_setting);
      if (drop_count != 0) begin
         drop_count--;
         return;
      end
      slot = (head_slot + held_count) % MAX_WINDOW;
      for (int c = 0; c < MAX_CHANNELS; c++)
         held_samples[slot][c] = (c < n_chan) ? sample[c*WORD_W +: WORD_W] : '0;
      held_count++;
      if (held_count < n_win)
         return;
      for (int i = 0; i < n_win; i++) begin
         row.lane  = held_samples[(head_slot + i) % MAX_WINDOW];
         row.index = i[SLOT_W-1:0];
         row.last  = (i == n_win - 1);
         expected_rows.push_back(row);
      end
      if (n_stride < n_win) begin
         head_slot = (head_slot + n_stride) % MAX_WINDOW;
         held_count -= n_stride;
      end else begin
         head_slot = 0;
         held_count = 0;
         drop_count = (n_stride - n_win) & 16'hFFFF;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_window_rows(req_tdata);
            samples_taken++;
         end
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= pending_samples.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rows.size() == 0) begin
            $error("row with nothing expected: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            fault_count++;
         end else begin
            oldest_row = expected_rows.pop_front();
            for (int c = 0; c < MAX_CHANNELS; c++)
               if (rsp_tdata[c*WORD_W +: WORD_W] !== oldest_row.lane[c]) begin
                  $error("row_ch%0d: expected %h, got %h", c, oldest_row.lane[c],
                         rsp_tdata[c*WORD_W +: WORD_W]);
                  fault_count++;
               end
            if (rsp_tdata[ROW_INDEX_LSB +: SLOT_W] !== oldest_row.index) begin
               $error("row_index: expected %0d, got %0d", oldest_row.index,
                      rsp_tdata[ROW_INDEX_LSB +: SLOT_W]);
               fault_count++;
            end
            if (rsp_tlast !== oldest_row.last) begin
               $error("last_row: expected %b, got %b", oldest_row.last, rsp_tlast);
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sliding_window_strider regression: fail");
         $finish;
      end
   end

   task automatic set_flow(flow_mode_type mode);
      @(negedge clock);
      case (mode)
         FLOW_STEADY:      begin send_idle_pct = 0;  sink_stall_pct = 0;  end
         FLOW_SENDER_IDLE: begin send_idle_pct = 82; sink_stall_pct = 0;  end
         FLOW_SINK_STALL:  begin send_idle_pct = 0;  sink_stall_pct = 82; end
         default:          begin send_idle_pct = 16; sink_stall_pct = 16; end
      endcase
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [STRIDE_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_setting(idx, value);
   endtask

   task automatic program_window(int chans, int win, int stride);
      write_csr(CSR_CHANNELS, chans[STRIDE_W-1:0]);
      write_csr(CSR_WINDOW, win[STRIDE_W-1:0]);
      write_csr(CSR_STRIDE, stride[STRIDE_W-1:0]);
   endtask

   task automatic queue_sample(logic [SAMPLE_W-1:0] sample);
      pending_samples.push_back(sample);
      samples_queued++;
   endtask

   task automatic queue_random(int count);
      @(negedge clock);
      repeat (count) queue_sample({$urandom, $urandom, $urandom, $urandom});
   endtask

   // hold until every item is taken and every row has left, then let the pipe empty
   task automatic settle();
      while (samples_taken != samples_queued || expected_rows.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int phase;
      int win;
      set_flow(FLOW_STEADY);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      queue_random(40);
      settle();

      set_flow(FLOW_SENDER_IDLE);
      program_window(7, 0, 0);
      @(negedge clock);
      queue_sample({4{32'h0000_0000}});
      queue_sample({4{32'hFFFF_FFFF}});
      queue_sample({4{32'hAAAA_AAAA}});
      queue_sample({4{32'h5555_5555}});
      queue_sample({32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001});
      queue_sample({32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0000});
      queue_random(2);
      settle();

      set_flow(FLOW_SINK_STALL);
      program_window(0, 3, 2);
      @(negedge clock);
      queue_sample({4{32'hFFFF_FFFF}});
      queue_sample({4{32'hFFFF_FFFF}});
      settle();
      write_csr(CSR_UNUSED, 16'hFFFF);
      queue_random(5);
      settle();

      set_flow(FLOW_STEADY);
      program_window(5, 2, 65535);
      queue_random(6);
      settle();

      set_flow(FLOW_BOTH_IDLE);
      program_window(2, 127, 1);
      queue_random(70);
      settle();

      // stall the result side long enough to back the block up into its input
      set_flow(FLOW_STEADY);
      program_window(4, 16, 3);
      queue_random(28);
      @(negedge clock);
      sink_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      sink_hold = 1'b0;
      settle();

      phase = 0;
      while (samples_queued < TARGET_ITEMS) begin
         set_flow(flow_mode_type'(phase % 4));
         win = $urandom_range(12);
         program_window($urandom_range(7), win,
                        ($urandom_range(7) == 0) ? 0 : $urandom_range(2 * win + 4, 1));
         queue_random($urandom_range(18, 10));
         settle();
         phase++;
      end

      while (samples_taken != samples_queued || expected_rows.size() != 0)
         @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && expected_rows.size() == 0)
         $display("sliding_window_strider regression: pass");
      else
         $display("sliding_window_strider regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/swst_pkg.sv
rtl/swst_ram.sv
rtl/swst_queue.sv
rtl/swst_front.sv
rtl/swst_back.sv
rtl/sliding_window_strider.sv
test/sliding_window_strider_tb.sv
